// ===== rtl/snfcs_pkg.sv =====
// Package for the SPI NOR flash command sequencer: codes, widths, reset values.
// No dependencies.
`default_nettype none
package snfcs_pkg;
   localparam int PAGE_SIZE_DEF = 256;
   localparam int TIMEOUT_BITS_DEF = 18;
   localparam int CFG_W = 18;

   localparam logic [3:0] CMD_ID = 4'd0;
   localparam logic [3:0] CMD_STATUS = 4'd1;
   localparam logic [3:0] CMD_READ = 4'd2;
   localparam logic [3:0] CMD_WRITE = 4'd3;
   localparam logic [3:0] CMD_WBYTE = 4'd4;
   localparam logic [3:0] CMD_SECTOR = 4'd5;
   localparam logic [3:0] CMD_BLOCK = 4'd6;
   localparam logic [3:0] CMD_CHIP = 4'd7;
   localparam logic [3:0] CMD_REPLY = 4'd8;
   localparam logic [3:0] CMD_TICK = 4'd9;

   localparam logic [1:0] ACT_XFER = 2'd0;
   localparam logic [1:0] ACT_DESEL = 2'd1;
   localparam logic [1:0] ACT_HOST = 2'd2;
   localparam logic [1:0] ACT_DONE = 2'd3;

   localparam logic [7:0] OP_RDID = 8'h9F;
   localparam logic [7:0] OP_RDSR = 8'h05;
   localparam logic [7:0] OP_WREN = 8'h06;
   localparam logic [7:0] OP_READ = 8'h03;
   localparam logic [7:0] OP_PP = 8'h02;
   localparam logic [7:0] OP_SE = 8'h20;
   localparam logic [7:0] OP_BE = 8'hD8;
   localparam logic [7:0] OP_CE = 8'hC7;
   localparam logic [7:0] OP_DUMMY = 8'hFF;

   localparam logic [2:0] REG_READY = 3'd0;
   localparam logic [2:0] REG_SECTOR = 3'd1;
   localparam logic [2:0] REG_BLOCK = 3'd2;
   localparam logic [2:0] REG_CHIP = 3'd3;
   localparam logic [2:0] REG_TOEN = 3'd4;

   localparam logic [CFG_W-1:0] RST_READY = 18'd1000;
   localparam logic [CFG_W-1:0] RST_SECTOR = 18'd5000;
   localparam logic [CFG_W-1:0] RST_BLOCK = 18'd10000;
   localparam logic [CFG_W-1:0] RST_CHIP = 18'd200000;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [23:0] address;
      logic [24:0] length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  bus_byte;
      logic        ok;
      logic [23:0] reply_value;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] ready_to;
      logic [CFG_W-1:0] sector_to;
      logic [CFG_W-1:0] block_to;
      logic [CFG_W-1:0] chip_to;
      logic             to_en;
   } cfg_type;
endpackage
`default_nettype wire

// ===== rtl/spi_nor_flash_command_sequencer.sv =====
// Top level of the SPI NOR flash command sequencer.
// Depends on snfcs_pkg, snfcs_csr, snfcs_seq, snfcs_fifo.
//  channel  | ports                                   | handshake
//  request  | req_cmd/address/length/data_byte        | push & !full
//  response | rsp_action/bus_byte/ok/reply_value/last | pop & !empty
//  config   | csr_psel..csr_pready                    | psel&penable&pwrite
// One request a cycle while full is low; the sequencer writes up to
// three results into a 16-entry queue. full rises when fewer than four slots
// are free; the response side drains one result a cycle while not empty.
// Reset clears sequencer state, queue and registers.
`default_nettype none
module spi_nor_flash_command_sequencer import snfcs_pkg::*; #(
   parameter int PAGE_SIZE = PAGE_SIZE_DEF,
   parameter int TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [3:0]  req_cmd,
   input  wire logic [23:0] req_address,
   input  wire logic [24:0] req_length,
   input  wire logic [7:0]  req_data_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_action,
   output logic [7:0]       rsp_bus_byte,
   output logic             rsp_ok,
   output logic [23:0]      rsp_reply_value,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   cfg_type cfg;
   req_type req;
   rsp_type rs [4];
   rsp_type head;
   logic [2:0] cnt;
   logic room;

   assign req = '{req_cmd, req_address, req_length, req_data_byte};
   assign full = !room;

   snfcs_csr u_csr (
      .clock, .reset, .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .cfg
   );

   snfcs_seq #(.PAGE_SIZE(PAGE_SIZE), .TIMEOUT_BITS(TIMEOUT_BITS)) u_seq (
      .clock, .reset, .in_valid(push && room), .in_req(req), .cfg,
      .out_count(cnt), .out_rsp(rs)
   );

   snfcs_fifo u_fifo (
      .clock, .reset, .wr_count(cnt), .wr_rsp(rs), .room, .pop, .empty, .head
   );

   assign rsp_action = head.action;
   assign rsp_bus_byte = head.bus_byte;
   assign rsp_ok = head.ok;
   assign rsp_reply_value = head.reply_value;
   assign rsp_last = head.last;
endmodule
`default_nettype wire

// ===== rtl/snfcs_csr.sv =====
// Configuration registers behind the APB-style port.
// Depends on snfcs_pkg.
`default_nettype none
module snfcs_csr import snfcs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output cfg_type          cfg
);
   cfg_type cfg_ff;
   logic [2:0] idx;
   assign idx = paddr[4:2];
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{RST_READY, RST_SECTOR, RST_BLOCK, RST_CHIP, 1'b1};
      end else if (psel && penable && pwrite) begin
         case (idx)
            REG_READY: cfg_ff.ready_to <= pwdata[CFG_W-1:0];
            REG_SECTOR: cfg_ff.sector_to <= pwdata[CFG_W-1:0];
            REG_BLOCK: cfg_ff.block_to <= pwdata[CFG_W-1:0];
            REG_CHIP: cfg_ff.chip_to <= pwdata[CFG_W-1:0];
            REG_TOEN: cfg_ff.to_en <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_READY: prdata = {14'd0, cfg_ff.ready_to};
         REG_SECTOR: prdata = {14'd0, cfg_ff.sector_to};
         REG_BLOCK: prdata = {14'd0, cfg_ff.block_to};
         REG_CHIP: prdata = {14'd0, cfg_ff.chip_to};
         REG_TOEN: prdata = {31'd0, cfg_ff.to_en};
         default: prdata = 32'd0;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/snfcs_seq.sv =====
// Front part: sequencer state; each request yields up to three results at once.
// Depends on snfcs_pkg.
`default_nettype none
module snfcs_seq import snfcs_pkg::*; #(
   parameter int PAGE_SIZE = PAGE_SIZE_DEF,
   parameter int TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  req_type      in_req,
   input  cfg_type      cfg,
   output logic [2:0]   out_count,
   output rsp_type      out_rsp [4]
);
   localparam int PW = $clog2(PAGE_SIZE);
   localparam int CW = (TIMEOUT_BITS > CFG_W) ? TIMEOUT_BITS : CFG_W;

   typedef enum logic [4:0] {
      S_IDLE, S_ID_CMD, S_ID_BYTE, S_ST_CMD, S_ST_BYTE, S_PRE_CMD, S_PRE_BYTE,
      S_WREN, S_WEL_CMD, S_WEL_BYTE, S_OPCODE, S_ADDR, S_READ_DATA,
      S_HOST_WAIT, S_PROG_DATA, S_POST_CMD, S_POST_BYTE
   } step_type;

   step_type step_ff, step_in;
   logic [2:0] op_ff, op_in;
   logic [23:0] addr_ff, addr_in;
   logic [24:0] left_ff, left_in;
   logic [PW:0] page_ff, page_in;
   logic [1:0] abi_ff, abi_in;
   logic [TIMEOUT_BITS-1:0] el_ff, el_in;
   logic [1:0] wk_ff, wk_in;
   logic [23:0] id_ff, id_in;
   logic [2:0] n;
   rsp_type r [4];
   logic [CFG_W-1:0] lim;
   logic [CW-1:0] limx;
   logic [CW-1:0] elx;
   logic [7:0] d;
   logic [PW:0] room;
   logic [24:0] dec;

   assign d = in_req.data_byte;
   assign dec = left_ff - 25'd1;
   assign limx = CW'(lim);
   assign elx = CW'(el_ff);

   always_comb begin
      case (wk_ff)
         2'd0: lim = cfg.ready_to;
         2'd1: lim = cfg.sector_to;
         2'd2: lim = cfg.block_to;
         default: lim = cfg.chip_to;
      endcase
   end

   function automatic logic [7:0] abyte(input logic [23:0] a, input logic [1:0] i);
      case (i)
         2'd0: abyte = a[23:16];
         2'd1: abyte = a[15:8];
         default: abyte = a[7:0];
      endcase
   endfunction

   always_comb begin
      logic [24:0] bl;
      logic [23:0] ca;
      logic [PW:0] rm;
      logic [PW:0] pl;
      step_in = step_ff; op_in = op_ff; addr_in = addr_ff; left_in = left_ff;
      page_in = page_ff; abi_in = abi_ff; el_in = el_ff; wk_in = wk_ff; id_in = id_ff;
      n = 3'd0;
      bl = 25'd0; ca = 24'd0; rm = '0; pl = '0;
      room = '0;
      for (int k = 0; k < 4; k++) r[k] = '0;
      if (in_valid) begin
         if (in_req.cmd == CMD_TICK) begin
            if (el_ff != {TIMEOUT_BITS{1'b1}}) el_in = el_ff + 1'b1;
         end else if (in_req.cmd == CMD_WBYTE) begin
            if (step_ff == S_HOST_WAIT) begin
               r[0] = '{ACT_XFER, d, 1'b0, 24'd0, 1'b0}; n = 3'd1;
               step_in = S_PROG_DATA;
            end
         end else if (in_req.cmd < CMD_REPLY && step_ff == S_IDLE) begin
            op_in = in_req.cmd[2:0];
            addr_in = in_req.address;
            left_in = in_req.length;
            rm = (PW+1)'(PAGE_SIZE) - {1'b0, in_req.address[PW-1:0]};
            case (in_req.cmd)
               CMD_ID: begin
                  id_in = 24'd0;
                  r[0] = '{ACT_XFER, OP_RDID, 1'b0, 24'd0, 1'b0}; n = 3'd1;
                  step_in = S_ID_CMD;
               end
               CMD_STATUS: begin
                  r[0] = '{ACT_XFER, OP_RDSR, 1'b0, 24'd0, 1'b0}; n = 3'd1;
                  step_in = S_ST_CMD;
               end
               CMD_WRITE: begin
                  if (in_req.length == 25'd0) begin
                     r[0] = '{ACT_DONE, 8'd0, 1'b1, 24'd0, 1'b0}; n = 3'd1;
                     step_in = S_IDLE;
                  end else begin
                     page_in = (in_req.length < 25'(rm)) ? (PW+1)'(in_req.length) : rm;
                     el_in = '0; wk_in = 2'd0;
                     r[0] = '{ACT_XFER, OP_RDSR, 1'b0, 24'd0, 1'b0}; n = 3'd1;
                     step_in = S_PRE_CMD;
                  end
               end
               default: begin
                  el_in = '0; wk_in = 2'd0;
                  r[0] = '{ACT_XFER, OP_RDSR, 1'b0, 24'd0, 1'b0}; n = 3'd1;
                  step_in = S_PRE_CMD;
               end
            endcase
         end else if (in_req.cmd == CMD_REPLY) begin
            case (step_ff)
               S_ID_CMD: begin
                  abi_in = 2'd0;
                  r[0] = '{ACT_XFER, OP_DUMMY, 1'b0, 24'd0, 1'b0}; n = 3'd1;
                  step_in = S_ID_BYTE;
               end
               S_ID_BYTE: begin
                  id_in = {id_ff[15:0], d};
                  if (abi_ff < 2'd2) begin
                     abi_in = abi_ff + 2'd1;
                     r[0] = '{ACT_XFER, OP_DUMMY, 1'b0, 24'd0, 1'b0}; n = 3'd1;
                  end else begin
                     r[0] = '{ACT_DESEL, 8'd0, 1'b0, 24'd0, 1'b0};
                     r[1] = '{ACT_DONE, 8'd0, 1'b1, {id_ff[15:0], d}, 1'b0}; n = 3'd2;
                     step_in = S_IDLE;
                  end
               end
               S_ST_CMD: begin
                  r[0] = '{ACT_XFER, OP_DUMMY, 1'b0, 24'd0, 1'b0}; n = 3'd1;
                  step_in = S_ST_BYTE;
               end
               S_ST_BYTE: begin
                  r[0] = '{ACT_DESEL, 8'd0, 1'b0, 24'd0, 1'b0};
                  r[1] = '{ACT_DONE, 8'd0, 1'b1, {16'd0, d}, 1'b0}; n = 3'd2;
                  step_in = S_IDLE;
               end
               S_PRE_CMD: begin
                  r[0] = '{ACT_XFER, OP_DUMMY, 1'b0, 24'd0, 1'b0}; n = 3'd1;
                  step_in = S_PRE_BYTE;
               end
               S_POST_CMD: begin
                  r[0] = '{ACT_XFER, OP_DUMMY, 1'b0, 24'd0, 1'b0}; n = 3'd1;
                  step_in = S_POST_BYTE;
               end
               S_PRE_BYTE, S_POST_BYTE: begin
                  r[0] = '{ACT_DESEL, 8'd0, 1'b0, 24'd0, 1'b0}; n = 3'd2;
                  if (d[0]) begin
                     if (cfg.to_en && (elx >= limx)) begin
                        r[1] = '{ACT_DONE, 8'd0, 1'b0, 24'd0, 1'b0};
                        step_in = S_IDLE;
                     end else begin
                        r[1] = '{ACT_XFER, OP_RDSR, 1'b0, 24'd0, 1'b0};
                        step_in = (step_ff == S_PRE_BYTE) ? S_PRE_CMD : S_POST_CMD;
                     end
                  end else if (step_ff == S_PRE_BYTE) begin
                     if (op_ff == CMD_READ[2:0]) begin
                        r[1] = '{ACT_XFER, OP_READ, 1'b0, 24'd0, 1'b0};
                        step_in = S_OPCODE;
                     end else begin
                        r[1] = '{ACT_XFER, OP_WREN, 1'b0, 24'd0, 1'b0};
                        step_in = S_WREN;
                     end
                  end else if (op_ff == CMD_WRITE[2:0] && left_ff != 25'd0) begin
                     room = (PW+1)'(PAGE_SIZE) - {1'b0, addr_ff[PW-1:0]};
                     page_in = (left_ff < 25'(room)) ? (PW+1)'(left_ff) : room;
                     el_in = '0; wk_in = 2'd0;
                     r[1] = '{ACT_XFER, OP_RDSR, 1'b0, 24'd0, 1'b0};
                     step_in = S_PRE_CMD;
                  end else begin
                     r[1] = '{ACT_DONE, 8'd0, 1'b1, 24'd0, 1'b0};
                     step_in = S_IDLE;
                  end
               end
               S_WREN: begin
                  r[0] = '{ACT_DESEL, 8'd0, 1'b0, 24'd0, 1'b0};
                  r[1] = '{ACT_XFER, OP_RDSR, 1'b0, 24'd0, 1'b0}; n = 3'd2;
                  step_in = S_WEL_CMD;
               end
               S_WEL_CMD: begin
                  r[0] = '{ACT_XFER, OP_DUMMY, 1'b0, 24'd0, 1'b0}; n = 3'd1;
                  step_in = S_WEL_BYTE;
               end
               S_WEL_BYTE: begin
                  r[0] = '{ACT_DESEL, 8'd0, 1'b0, 24'd0, 1'b0}; n = 3'd2;
                  if (d[1]) begin
                     case (op_ff)
                        CMD_SECTOR[2:0]: r[1] = '{ACT_XFER, OP_SE, 1'b0, 24'd0, 1'b0};
                        CMD_BLOCK[2:0]: r[1] = '{ACT_XFER, OP_BE, 1'b0, 24'd0, 1'b0};
                        CMD_CHIP[2:0]: r[1] = '{ACT_XFER, OP_CE, 1'b0, 24'd0, 1'b0};
                        default: r[1] = '{ACT_XFER, OP_PP, 1'b0, 24'd0, 1'b0};
                     endcase
                     step_in = S_OPCODE;
                  end else begin
                     r[1] = '{ACT_DONE, 8'd0, 1'b0, 24'd0, 1'b0};
                     step_in = S_IDLE;
                  end
               end
               S_OPCODE: begin
                  if (op_ff == CMD_CHIP[2:0]) begin
                     r[0] = '{ACT_DESEL, 8'd0, 1'b0, 24'd0, 1'b0};
                     r[1] = '{ACT_XFER, OP_RDSR, 1'b0, 24'd0, 1'b0}; n = 3'd2;
                     el_in = '0; wk_in = 2'd3;
                     step_in = S_POST_CMD;
                  end else begin
                     abi_in = 2'd0;
                     r[0] = '{ACT_XFER, abyte(addr_ff, 2'd0), 1'b0, 24'd0, 1'b0}; n = 3'd1;
                     step_in = S_ADDR;
                  end
               end
               S_ADDR: begin
                  if (abi_ff < 2'd2) begin
                     abi_in = abi_ff + 2'd1;
                     r[0] = '{ACT_XFER, abyte(addr_ff, abi_ff + 2'd1), 1'b0, 24'd0, 1'b0};
                     n = 3'd1;
                  end else if (op_ff == CMD_READ[2:0]) begin
                     if (left_ff == 25'd0) begin
                        r[0] = '{ACT_DESEL, 8'd0, 1'b0, 24'd0, 1'b0};
                        r[1] = '{ACT_DONE, 8'd0, 1'b1, 24'd0, 1'b0}; n = 3'd2;
                        step_in = S_IDLE;
                     end else begin
                        r[0] = '{ACT_XFER, OP_DUMMY, 1'b0, 24'd0, 1'b0}; n = 3'd1;
                        step_in = S_READ_DATA;
                     end
                  end else if (op_ff == CMD_WRITE[2:0]) begin
                     step_in = S_HOST_WAIT;
                  end else begin
                     r[0] = '{ACT_DESEL, 8'd0, 1'b0, 24'd0, 1'b0};
                     r[1] = '{ACT_XFER, OP_RDSR, 1'b0, 24'd0, 1'b0}; n = 3'd2;
                     el_in = '0;
                     wk_in = (op_ff == CMD_SECTOR[2:0]) ? 2'd1 : 2'd2;
                     step_in = S_POST_CMD;
                  end
               end
               S_READ_DATA: begin
                  bl = dec; ca = addr_ff + 24'd1;
                  left_in = bl; addr_in = ca;
                  r[0] = '{ACT_HOST, d, 1'b0, 24'd0, 1'b0};
                  if (bl == 25'd0) begin
                     r[1] = '{ACT_DESEL, 8'd0, 1'b0, 24'd0, 1'b0};
                     r[2] = '{ACT_DONE, 8'd0, 1'b1, 24'd0, 1'b0}; n = 3'd3;
                     step_in = S_IDLE;
                  end else begin
                     r[1] = '{ACT_XFER, OP_DUMMY, 1'b0, 24'd0, 1'b0}; n = 3'd2;
                  end
               end
               S_PROG_DATA: begin
                  bl = dec; ca = addr_ff + 24'd1;
                  left_in = bl; addr_in = ca;
                  pl = (page_ff != '0) ? page_ff - 1'b1 : page_ff;
                  page_in = pl;
                  if (pl == '0 || bl == 25'd0) begin
                     r[0] = '{ACT_DESEL, 8'd0, 1'b0, 24'd0, 1'b0};
                     r[1] = '{ACT_XFER, OP_RDSR, 1'b0, 24'd0, 1'b0}; n = 3'd2;
                     el_in = '0; wk_in = 2'd0;
                     step_in = S_POST_CMD;
                  end else begin
                     step_in = S_HOST_WAIT;
                  end
               end
               default: ;
            endcase
         end
      end
      for (int k = 0; k < 4; k++) r[k].last = (3'(k) == n - 3'd1);
      out_count = n;
      for (int k = 0; k < 4; k++) out_rsp[k] = r[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE; op_ff <= '0; addr_ff <= '0; left_ff <= '0; page_ff <= '0;
         abi_ff <= '0; el_ff <= '0; wk_ff <= '0; id_ff <= '0;
      end else begin
         step_ff <= step_in; op_ff <= op_in; addr_ff <= addr_in; left_ff <= left_in;
         page_ff <= page_in; abi_ff <= abi_in; el_ff <= el_in; wk_ff <= wk_in;
         id_ff <= id_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/snfcs_fifo.sv =====
// Back part: result queue; takes up to four results a cycle, hands out one.
// Depends on snfcs_pkg.
`default_nettype none
module snfcs_fifo import snfcs_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic [2:0] wr_count,
   input  rsp_type    wr_rsp [4],
   output logic       room,
   input  wire logic  pop,
   output logic       empty,
   output rsp_type    head
);
   localparam int DEPTH = 16;
   localparam int AW = 4;
   rsp_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff, cnt_in;
   logic do_pop;

   assign empty = (cnt_ff == '0);
   assign do_pop = pop && !empty;
   assign room = (cnt_ff <= (AW+1)'(DEPTH - 4));
   assign head = mem_ff[rp_ff];
   assign cnt_in = cnt_ff + (AW+1)'(wr_count) - (AW+1)'(do_pop);

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++)
         if (3'(k) < wr_count) mem_ff[wp_ff + AW'(k)] <= wr_rsp[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_ff + AW'(wr_count);
         rp_ff <= rp_ff + AW'(do_pop);
         cnt_ff <= cnt_in;
      end
   end

   a_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue overflow");
   a_nowrite_full: assert property (@(posedge clock) disable iff (reset)
      !room |-> wr_count == 3'd0) else $error("write without room");
   a_count: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> cnt_ff == $past(cnt_in)) else $error("count slip");
endmodule
`default_nettype wire
